/* rtl/tgp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgp_pkg
// Shared types, constants and a helper function for the thresholded global
// pooling core.
// ----------------------------------------------------------------------------
package tgp_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 32;
   localparam int COUNT_W  = 13;
   localparam int POS_W    = 12;

   // longest plane the position counter tracks before it saturates
   localparam int PLANE_MAX = 4096;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'((PLANE_MAX - 1) % (2 ** POS_W));
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // plane summary queue depth (2..16)
   localparam int QUEUE_DEPTH = 2;

   // pool modes
   localparam logic MODE_SUM     = 1'b0;
   localparam logic MODE_AVG_MAX = 1'b1;

   // csr register indexes
   localparam logic REG_POOL_MODE = 1'b0;
   localparam logic REG_THRESHOLD = 1'b1;

   // one finished plane, already classified by the front end
   typedef struct packed {
      logic [SUM_W-1:0]   value;
      logic [COUNT_W-1:0] count;
      logic [POS_W-1:0]   max_pos;
      logic               fell_back;
      logic               divide;
   } entry_type;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                input logic [SAMPLE_W-1:0] smp);
      logic [SUM_W:0] sum;
      sum = {acc[SUM_W-1], acc} + {{(SUM_W-SAMPLE_W+1){smp[SAMPLE_W-1]}}, smp};
      if (sum[SUM_W] != sum[SUM_W-1]) begin
         return sum[SUM_W] ? SUM_MIN : SUM_MAX;
      end
      return sum[SUM_W-1:0];
   endfunction

endpackage

/* rtl/tgp_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgp_req_if
// Sample channel: one signed Q8.8 sample per transaction with a plane-end flag.
// ----------------------------------------------------------------------------
interface tgp_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [tgp_pkg::SAMPLE_W-1:0]   sample;
   logic                                  last_of_plane;

   modport source (output valid, output sample, output last_of_plane, input ready);
   modport sink   (input valid, input sample, input last_of_plane, output ready);
endinterface

/* rtl/tgp_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgp_rsp_if
// Result channel: one pooled result per plane.
// ----------------------------------------------------------------------------
interface tgp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [tgp_pkg::SUM_W-1:0]     pooled_value;
   logic [tgp_pkg::COUNT_W-1:0]          count_above;
   logic [tgp_pkg::POS_W-1:0]            max_position;
   logic                                 fell_back;

   modport source (output valid, output pooled_value, output count_above,
                   output max_position, output fell_back, input ready);
   modport sink   (input valid, input pooled_value, input count_above,
                   input max_position, input fell_back, output ready);
endinterface

/* rtl/tgp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgp_front
// Per-sample accumulation and plane-end classification into a summary entry.
// ----------------------------------------------------------------------------
module tgp_front (
   input  logic                           clock,
   input  logic                           reset,
   tgp_req_if.sink                        req_bus,
   input  logic                           pool_mode,
   input  logic [tgp_pkg::SAMPLE_W-1:0]   threshold,
   input  logic                           queue_full,
   output logic                           push,
   output tgp_pkg::entry_type             push_entry
);

   logic [tgp_pkg::SUM_W-1:0]    passing_sum_ff, passing_sum_in;
   logic [tgp_pkg::SUM_W-1:0]    total_sum_ff, total_sum_in;
   logic [tgp_pkg::COUNT_W-1:0]  pass_count_ff, pass_count_in;
   logic [tgp_pkg::SAMPLE_W-1:0] running_max_ff, running_max_in;
   logic [tgp_pkg::POS_W-1:0]    max_pos_ff, max_pos_in;
   logic [tgp_pkg::POS_W-1:0]    position_ff, position_in;
   logic                         accept;
   logic                         passes;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign passes        = $signed(req_bus.sample) >= $signed(threshold);

   always_comb begin
      total_sum_in   = tgp_pkg::sat_add(total_sum_ff, req_bus.sample);
      passing_sum_in = passing_sum_ff;
      pass_count_in  = pass_count_ff;
      running_max_in = running_max_ff;
      max_pos_in     = max_pos_ff;
      position_in    = position_ff;
      if ($signed(req_bus.sample) > $signed(running_max_ff)) begin
         running_max_in = req_bus.sample;
         max_pos_in     = position_ff;
      end
      if (passes) begin
         passing_sum_in = tgp_pkg::sat_add(passing_sum_ff, req_bus.sample);
         if (pass_count_ff != tgp_pkg::COUNT_MAX) begin
            pass_count_in = pass_count_ff + 1'b1;
         end
      end
      if (position_ff != tgp_pkg::POS_LIMIT) begin
         position_in = position_ff + 1'b1;
      end
   end

   // plane-end classification
   always_comb begin
      push_entry.count     = pass_count_in;
      push_entry.max_pos   = '0;
      push_entry.fell_back = 1'b0;
      push_entry.divide    = 1'b0;
      push_entry.value     = passing_sum_in;
      if (pass_count_in == '0) begin
         push_entry.fell_back = 1'b1;
         if (pool_mode == tgp_pkg::MODE_AVG_MAX) begin
            push_entry.value   = {{(tgp_pkg::SUM_W-tgp_pkg::SAMPLE_W){running_max_in[tgp_pkg::SAMPLE_W-1]}},
                                  running_max_in};
            push_entry.max_pos = max_pos_in;
         end else begin
            push_entry.value = total_sum_in;
         end
      end else if (pool_mode == tgp_pkg::MODE_AVG_MAX) begin
         push_entry.divide = 1'b1;
      end
   end

   assign push = accept && req_bus.last_of_plane;

   always_ff @(posedge clock) begin
      if (reset || push) begin
         passing_sum_ff <= '0;
         total_sum_ff   <= '0;
         pass_count_ff  <= '0;
         running_max_ff <= tgp_pkg::SAMPLE_MIN;
         max_pos_ff     <= '0;
         position_ff    <= '0;
      end else if (accept) begin
         passing_sum_ff <= passing_sum_in;
         total_sum_ff   <= total_sum_in;
         pass_count_ff  <= pass_count_in;
         running_max_ff <= running_max_in;
         max_pos_ff     <= max_pos_in;
         position_ff    <= position_in;
      end
   end

endmodule

/* rtl/tgp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgp_queue
// Small register queue of plane summaries between front and back end.
// ----------------------------------------------------------------------------
module tgp_queue #(
   parameter int DEPTH = tgp_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tgp_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output tgp_pkg::entry_type head_entry,
   output logic               empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   tgp_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign empty      = count_ff == '0;
   assign head_entry = mem_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("summary pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("summary popped from empty queue");

endmodule

/* rtl/tgp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgp_back
// Executes plane summaries: bit-serial average divide and result register.
// ----------------------------------------------------------------------------
module tgp_back (
   input  logic               clock,
   input  logic               reset,
   input  tgp_pkg::entry_type head_entry,
   input  logic               queue_empty,
   output logic               pop,
   tgp_rsp_if.source          rsp_bus
);

   localparam int STEP_W = $clog2(tgp_pkg::SUM_W);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_OUTPUT = 3'b100
   } state_type;

   state_type                    state_ff, state_in;
   logic [tgp_pkg::SUM_W-1:0]    quo_ff, quo_in;
   logic [tgp_pkg::COUNT_W-1:0]  rem_ff, rem_in;
   logic [tgp_pkg::COUNT_W-1:0]  div_ff;
   logic                         neg_ff;
   logic [STEP_W-1:0]            step_ff;
   logic [tgp_pkg::SUM_W-1:0]    value_ff;
   logic [tgp_pkg::COUNT_W-1:0]  count_ff;
   logic [tgp_pkg::POS_W-1:0]    pos_ff;
   logic                         fb_ff;
   logic [tgp_pkg::COUNT_W:0]    partial;
   logic [tgp_pkg::COUNT_W+1:0]  diff;
   logic                         take;
   logic [tgp_pkg::SUM_W-1:0]    head_abs;

   assign pop = (state_ff == ST_IDLE) && !queue_empty;

   assign head_abs = head_entry.value[tgp_pkg::SUM_W-1] ? (~head_entry.value + 1'b1)
                                                        : head_entry.value;

   // one restoring step per cycle
   always_comb begin
      partial = {rem_ff, quo_ff[tgp_pkg::SUM_W-1]};
      diff    = {1'b0, partial} - {2'b00, div_ff};
      take    = !diff[tgp_pkg::COUNT_W+1];
      rem_in  = take ? diff[tgp_pkg::COUNT_W-1:0] : partial[tgp_pkg::COUNT_W-1:0];
      quo_in  = {quo_ff[tgp_pkg::SUM_W-2:0], take};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               state_in = head_entry.divide ? ST_DIVIDE : ST_OUTPUT;
            end
         end
         ST_DIVIDE: begin
            if (step_ff == '0) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         count_ff <= head_entry.count;
         pos_ff   <= head_entry.max_pos;
         fb_ff    <= head_entry.fell_back;
         value_ff <= head_entry.value;
         quo_ff   <= head_abs;
         rem_ff   <= '0;
         div_ff   <= head_entry.count;
         neg_ff   <= head_entry.value[tgp_pkg::SUM_W-1];
         step_ff  <= STEP_W'(tgp_pkg::SUM_W - 1);
      end else if (state_ff == ST_DIVIDE) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff - 1'b1;
         if (step_ff == '0) begin
            value_ff <= neg_ff ? (~quo_in + 1'b1) : quo_in;
         end
      end
   end

   assign rsp_bus.valid        = state_ff == ST_OUTPUT;
   assign rsp_bus.pooled_value = value_ff;
   assign rsp_bus.count_above  = count_ff;
   assign rsp_bus.max_position = pos_ff;
   assign rsp_bus.fell_back    = fb_ff;

   a_fallback_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.fell_back) |-> (rsp_bus.count_above == '0))
      else $error("fallback result with nonzero pass count");

   a_position_fallback: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.max_position != '0) |-> rsp_bus.fell_back)
      else $error("max position reported without fallback");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (div_ff != '0))
      else $error("average divide with zero count");

endmodule

/* rtl/threshold_global_pooling_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_global_pooling_core
// Thresholded global sum / average-with-max-fallback pooling of one plane.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   req_bus   in         valid/ready            sample, last_of_plane
//   rsp_bus   out        valid/ready            pooled_value, count_above,
//                                               max_position, fell_back
//   csr       in         apb psel/penable       pool_mode (0x0), threshold (0x4)
//
// - front end takes one sample per cycle while the summary queue is not
//   full; plane stats update in that cycle
// - each plane end pushes one summary into a QUEUE_DEPTH-entry queue
// - back end takes one summary at a time; averages need a bit-serial divide
// - req_bus.ready drops only while the summary queue is full
// - synchronous active-high reset clears plane state, queue and csr registers
//
module threshold_global_pooling_core #(
   parameter int QUEUE_DEPTH = tgp_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   tgp_req_if.sink     req_bus,
   tgp_rsp_if.source   rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                         pool_mode_ff;
   logic [tgp_pkg::SAMPLE_W-1:0] threshold_ff;
   logic                         csr_write;
   logic                         push;
   logic                         pop;
   logic                         queue_full;
   logic                         queue_empty;
   tgp_pkg::entry_type           push_entry;
   tgp_pkg::entry_type           head_entry;

   // csr port: zero wait states, register index in address bit 2
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_mode_ff <= tgp_pkg::MODE_SUM;
         threshold_ff <= '0;
      end else if (csr_write) begin
         case (paddr[2])
            tgp_pkg::REG_POOL_MODE: pool_mode_ff <= pwdata[0];
            tgp_pkg::REG_THRESHOLD: threshold_ff <= pwdata[tgp_pkg::SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         tgp_pkg::REG_POOL_MODE: prdata = {31'b0, pool_mode_ff};
         tgp_pkg::REG_THRESHOLD: prdata = {{(32-tgp_pkg::SAMPLE_W){threshold_ff[tgp_pkg::SAMPLE_W-1]}},
                                           threshold_ff};
         default: prdata = '0;
      endcase
   end

   // accumulation and classification; mode is taken at the plane end
   tgp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .pool_mode  (pool_mode_ff),
      .threshold  (threshold_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // decouples the sample stream from the per-plane divide
   tgp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_entry (head_entry),
      .empty      (queue_empty)
   );

   // divide and result register
   tgp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_entry  (head_entry),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_bus     (rsp_bus)
   );

endmodule
